FILE: src/wilder_rsi_tracker_unit_assert.svh
// Assertion macros for the RSI tracker, empty when SYNTH is defined.
`ifndef WILDER_RSI_TRACKER_UNIT_ASSERT_SVH
`define WILDER_RSI_TRACKER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define WRT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wilder rsi tracker: assertion failed");
// Next-cycle implication.
`define WRT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wilder rsi tracker: assertion failed");
`else
`define WRT_ASSERT_IMP(lbl, ante, cons)
`define WRT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: src/wrt_pkg.sv
// Shared constants and types for the RSI tracker.
package wrt_pkg;

  localparam int PRICE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_PERIOD  = 255;

  localparam int PERIOD_W = 8;
  localparam int FLOOR_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int COUNT_W  = 9;

  localparam int SUM_W  = PRICE_WIDTH + 8;
  localparam int AVG_W  = PRICE_WIDTH + 16;
  localparam int RSI_W  = FRAC_BITS + 7;
  localparam int RSI_SHIFT = RSI_W - FRAC_BITS;
  localparam int PROD_W = AVG_W + 7;

  localparam int REM_W  = AVG_W + 2;
  localparam int DIVD_W = AVG_W;
  localparam int STEPS_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOSS_FLOOR = 1'd1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
  localparam logic [FLOOR_W-1:0]  FLOOR_RESET  = 16'd1;

  localparam logic [RSI_W-1:0] RSI_FULL = RSI_W'(100 << FRAC_BITS);
  localparam logic [RSI_W-1:0] RSI_HALF = RSI_W'(50 << FRAC_BITS);

  localparam logic [STEPS_W-1:0] STEPS_AVG = STEPS_W'(DIVD_W);
  localparam logic [STEPS_W-1:0] STEPS_RSI = STEPS_W'(RSI_W);

  typedef struct packed {
    logic               start;
    logic [STEPS_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: src/wrt_div.sv
// Shared restoring divider: one quotient bit per cycle.
module wrt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  wrt_pkg::div_ctl_t          ctl,
  input  logic [wrt_pkg::REM_W-1:0]  rem_init,
  input  logic [wrt_pkg::DIVD_W-1:0] dividend,
  input  logic [wrt_pkg::REM_W-1:0]  divisor,
  output wrt_pkg::div_stat_t         stat,
  output logic [wrt_pkg::DIVD_W-1:0] quotient
);

  logic [wrt_pkg::REM_W-1:0]   rem;
  logic [wrt_pkg::DIVD_W-1:0]  dvd;
  logic [wrt_pkg::REM_W-1:0]   dsr;
  logic [wrt_pkg::STEPS_W-1:0] cnt;
  logic                        busy;
  logic                        done;
  logic [wrt_pkg::REM_W-1:0]   r_shift;
  logic [wrt_pkg::REM_W-1:0]   r_sub;
  logic                        fits;

  always_comb begin
    r_shift = {rem[wrt_pkg::REM_W-2:0], dvd[wrt_pkg::DIVD_W-1]};
    fits    = (r_shift >= dsr);
    r_sub   = r_shift - dsr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Pulse done for one cycle once the last quotient bit is in.
      done <= busy && !ctl.start && (cnt == wrt_pkg::STEPS_W'(1));
      if (ctl.start) begin
        cnt  <= ctl.steps;
        busy <= 1'b1;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == wrt_pkg::STEPS_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= rem_init;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? r_sub : r_shift;
      dvd <= {dvd[wrt_pkg::DIVD_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dvd;

endmodule

FILE: src/wilder_rsi_tracker_unit.sv
// Top level of the Wilder-smoothed relative strength index tracker.
// Work per price: the first price is only stored and repeats the held index; a warm-up
// price with no seeding only updates the sums; a seeding or smoothing price runs two 48-step
// divisions by the period and, unless the loss floor or zero averages settle the index, a
// 23-step index division on one shared serial divider; a new price is taken only when idle.
// Reset (synchronous, rst high): state cleared, period 14, loss floor 1, index 50.0.
`include "wilder_rsi_tracker_unit_assert.svh"

module wilder_rsi_tracker_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [wrt_pkg::PRICE_WIDTH-1:0] close_price,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [wrt_pkg::RSI_W-1:0]      rsi_out,
  output logic                           warm,
  input  logic                           cfg_wr_en,
  input  logic [wrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrt_pkg::CFG_W-1:0]      cfg_data
);

  // Sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ACC   = 4'd1;
  localparam logic [3:0] ST_GDIV  = 4'd2;
  localparam logic [3:0] ST_GWAIT = 4'd3;
  localparam logic [3:0] ST_LDIV  = 4'd4;
  localparam logic [3:0] ST_LWAIT = 4'd5;
  localparam logic [3:0] ST_WARM  = 4'd6;
  localparam logic [3:0] ST_RSI   = 4'd7;
  localparam logic [3:0] ST_RWAIT = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;

  logic [3:0] state;

  // Configuration registers
  logic [wrt_pkg::PERIOD_W-1:0] period;
  logic [wrt_pkg::FLOOR_W-1:0]  loss_floor;

  // Tracker state
  logic [wrt_pkg::PRICE_WIDTH-1:0] last_price;
  logic                            seen_first;
  logic [wrt_pkg::COUNT_W-1:0]     sample_count;
  logic [wrt_pkg::SUM_W-1:0]       gain_sum;
  logic [wrt_pkg::SUM_W-1:0]       loss_sum;
  logic [wrt_pkg::AVG_W-1:0]       gain_avg;
  logic [wrt_pkg::AVG_W-1:0]       loss_avg;
  logic [wrt_pkg::RSI_W-1:0]       last_rsi;

  // Per-item working registers
  logic [wrt_pkg::PRICE_WIDTH-1:0] cur_price;
  logic [wrt_pkg::PRICE_WIDTH-1:0] gain_x;
  logic [wrt_pkg::PRICE_WIDTH-1:0] loss_x;
  logic                            seed_mode;
  logic                            step_up;
  logic                            warm_flag;
  logic [wrt_pkg::AVG_W:0]         sum_gl;
  logic [wrt_pkg::PROD_W-1:0]      prod;

  // Combinational helpers
  logic [wrt_pkg::PERIOD_W-1:0] p_eff;
  logic [wrt_pkg::COUNT_W-1:0]  p_cnt;
  logic [wrt_pkg::SUM_W:0]      gsum_add;
  logic [wrt_pkg::SUM_W:0]      lsum_add;
  logic [wrt_pkg::AVG_W-1:0]    gx_ext;
  logic [wrt_pkg::AVG_W-1:0]    lx_ext;
  logic                         g_up;
  logic                         l_up;
  logic [wrt_pkg::PROD_W-1:0]   g_wide;
  logic                         accept;
  logic                         out_free;

  // Divider hookup
  wrt_pkg::div_ctl_t          div_ctl;
  wrt_pkg::div_stat_t         div_stat;
  logic [wrt_pkg::REM_W-1:0]  div_rem_init;
  logic [wrt_pkg::DIVD_W-1:0] div_dividend;
  logic [wrt_pkg::REM_W-1:0]  div_divisor;
  logic [wrt_pkg::DIVD_W-1:0] div_q;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // A period of zero acts as one; clamp to the supported maximum.
  always_comb begin
    p_eff = period;
    if (period == '0) p_eff = wrt_pkg::PERIOD_W'(1);
    if ({1'b0, period} > (wrt_pkg::PERIOD_W+1)'(wrt_pkg::MAX_PERIOD)) begin
      p_eff = wrt_pkg::PERIOD_W'(wrt_pkg::MAX_PERIOD);
    end
    p_cnt = {{(wrt_pkg::COUNT_W-wrt_pkg::PERIOD_W){1'b0}}, p_eff};
  end

  always_comb begin
    gsum_add = {1'b0, gain_sum} + {{(wrt_pkg::SUM_W+1-wrt_pkg::PRICE_WIDTH){1'b0}}, gain_x};
    lsum_add = {1'b0, loss_sum} + {{(wrt_pkg::SUM_W+1-wrt_pkg::PRICE_WIDTH){1'b0}}, loss_x};
    gx_ext   = {{(wrt_pkg::AVG_W-wrt_pkg::PRICE_WIDTH){1'b0}}, gain_x};
    lx_ext   = {{(wrt_pkg::AVG_W-wrt_pkg::PRICE_WIDTH){1'b0}}, loss_x};
    g_up     = (gx_ext >= gain_avg);
    l_up     = (lx_ext >= loss_avg);
    // Gain average widened for the times-one-hundred product, which is built from shifts and adds.
    g_wide   = {{(wrt_pkg::PROD_W-wrt_pkg::AVG_W){1'b0}}, gain_avg};
  end

  // Drive the shared divider from the sequencer state.
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = wrt_pkg::STEPS_AVG;
    div_rem_init  = '0;
    div_dividend  = '0;
    div_divisor   = {{(wrt_pkg::REM_W-wrt_pkg::PERIOD_W){1'b0}}, p_eff};
    case (state)
      ST_GDIV: begin
        div_ctl.start = 1'b1;
        if (seed_mode) begin
          div_dividend = {{(wrt_pkg::DIVD_W-wrt_pkg::SUM_W){1'b0}}, gain_sum};
        end else begin
          div_dividend = g_up ? (gx_ext - gain_avg) : (gain_avg - gx_ext);
        end
      end
      ST_LDIV: begin
        div_ctl.start = 1'b1;
        if (seed_mode) begin
          div_dividend = {{(wrt_pkg::DIVD_W-wrt_pkg::SUM_W){1'b0}}, loss_sum};
        end else begin
          div_dividend = l_up ? (lx_ext - loss_avg) : (loss_avg - lx_ext);
        end
      end
      ST_RSI: begin
        // Index = prod * 2^FRAC_BITS / sum. The quotient fits RSI_W bits, so preload the
        // remainder with the upper part and shift only the low RSI_W bits through.
        div_ctl.start = (sum_gl != '0);
        div_ctl.steps = wrt_pkg::STEPS_RSI;
        div_rem_init  = {{(wrt_pkg::REM_W-wrt_pkg::AVG_W){1'b0}},
                         prod[wrt_pkg::PROD_W-1:wrt_pkg::RSI_SHIFT]};
        div_dividend  = {prod[wrt_pkg::RSI_SHIFT-1:0],
                         {(wrt_pkg::DIVD_W-wrt_pkg::RSI_SHIFT){1'b0}}};
        div_divisor   = {{(wrt_pkg::REM_W-wrt_pkg::AVG_W-1){1'b0}}, sum_gl};
      end
      default: begin
        div_ctl.start = 1'b0;
      end
    endcase
  end

  wrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Configuration writes; an index outside the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      period     <= wrt_pkg::PERIOD_RESET;
      loss_floor <= wrt_pkg::FLOOR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wrt_pkg::REG_PERIOD:     period     <= cfg_data[wrt_pkg::PERIOD_W-1:0];
        wrt_pkg::REG_LOSS_FLOOR: loss_floor <= cfg_data[wrt_pkg::FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      last_price   <= '0;
      seen_first   <= 1'b0;
      sample_count <= '0;
      gain_sum     <= '0;
      loss_sum     <= '0;
      gain_avg     <= '0;
      loss_avg     <= '0;
      last_rsi     <= wrt_pkg::RSI_HALF;
      warm_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // Raise valid when a result is handed over, drop it once the transfer is done.
      if (state == ST_EMIT && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready)  out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cur_price <= close_price;
            if (close_price > last_price) begin
              gain_x <= close_price - last_price;
              loss_x <= '0;
            end else begin
              gain_x <= '0;
              loss_x <= last_price - close_price;
            end
            if (!seen_first) begin
              // First price: store it and repeat the held index, not warm.
              last_price   <= close_price;
              seen_first   <= 1'b1;
              sample_count <= wrt_pkg::COUNT_W'(1);
              warm_flag    <= 1'b0;
              state        <= ST_EMIT;
            end else begin
              state <= ST_ACC;
            end
          end
        end
        ST_ACC: begin
          if (sample_count <= p_cnt) begin
            // Seeding window: saturating sums.
            gain_sum <= gsum_add[wrt_pkg::SUM_W] ? '1 : gsum_add[wrt_pkg::SUM_W-1:0];
            loss_sum <= lsum_add[wrt_pkg::SUM_W] ? '1 : lsum_add[wrt_pkg::SUM_W-1:0];
            seed_mode <= 1'b1;
            state     <= (sample_count == p_cnt) ? ST_GDIV : ST_FIN;
          end else begin
            seed_mode <= 1'b0;
            state     <= ST_GDIV;
          end
        end
        ST_GDIV: begin
          step_up <= g_up;
          state   <= ST_GWAIT;
        end
        ST_GWAIT: begin
          if (div_stat.done) begin
            if (seed_mode)    gain_avg <= div_q;
            else if (step_up) gain_avg <= gain_avg + div_q;
            else              gain_avg <= gain_avg - div_q;
            state <= ST_LDIV;
          end
        end
        ST_LDIV: begin
          step_up <= l_up;
          state   <= ST_LWAIT;
        end
        ST_LWAIT: begin
          if (div_stat.done) begin
            if (seed_mode)    loss_avg <= div_q;
            else if (step_up) loss_avg <= loss_avg + div_q;
            else              loss_avg <= loss_avg - div_q;
            state <= ST_WARM;
          end
        end
        ST_WARM: begin
          if (loss_avg < {{(wrt_pkg::AVG_W-wrt_pkg::FLOOR_W){1'b0}}, loss_floor}) begin
            last_rsi <= wrt_pkg::RSI_FULL;
            state    <= ST_FIN;
          end else begin
            sum_gl <= {1'b0, gain_avg} + {1'b0, loss_avg};
            prod   <= (g_wide << 6) + (g_wide << 5) + (g_wide << 2);
            state  <= ST_RSI;
          end
        end
        ST_RSI: begin
          if (sum_gl == '0) begin
            // Both averages zero: neutral index.
            last_rsi <= wrt_pkg::RSI_HALF;
            state    <= ST_FIN;
          end else begin
            state <= ST_RWAIT;
          end
        end
        ST_RWAIT: begin
          if (div_stat.done) begin
            last_rsi <= div_q[wrt_pkg::RSI_W-1:0];
            state    <= ST_FIN;
          end
        end
        ST_FIN: begin
          warm_flag  <= (sample_count >= p_cnt);
          last_price <= cur_price;
          if (sample_count <= p_cnt) sample_count <= sample_count + 1'b1;
          else                       sample_count <= p_cnt + 1'b1;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // Hold until the output register is free, then hand the result over.
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      rsi_out <= last_rsi;
      warm    <= warm_flag;
    end
  end

  `WRT_ASSERT_IMP(a_rsi_range, out_valid, rsi_out <= wrt_pkg::RSI_FULL)
  `WRT_ASSERT_IMP(a_warm_seen, out_valid && warm, seen_first)
  `WRT_ASSERT_NXT(a_first_emit, accept && !seen_first, state == ST_EMIT)
  `WRT_ASSERT_IMP(a_div_idle_start, div_ctl.start, !div_stat.busy)
  `WRT_ASSERT_IMP(a_count_reset, !seen_first, sample_count == '0)

endmodule
